// ===== design/bfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfu_pkg
// Shared widths, codes and types of the boid flocking update block.
// ----------------------------------------------------------------------------
package bfu_pkg;

    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;

    localparam int SQ_W       = 2 * RAD_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int FRAC_W     = 16;
    localparam int DIV_NUM_W  = RAD_W + FRAC_W;
    localparam int DIV_DEN_W  = ROOT_W;
    localparam int SEP_W      = 25;
    localparam int SUM_W      = 39;
    localparam int NUMS_W     = 40;
    localparam int TDEN_W     = 12;
    localparam int T_W        = 34;
    localparam int ALIGN_DIV  = 20;

    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALI    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COH    = 2'd3;

    localparam logic [CNT_W-1:0] RST_ACTIVE = 7'd1;
    localparam logic [RAD_W-1:0] RST_SEP    = 31'd655360;
    localparam logic [RAD_W-1:0] RST_ALI    = 31'd1310720;
    localparam logic [RAD_W-1:0] RST_COH    = 31'd1966080;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

// ===== design/bfu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfu_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bfu_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfu_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module bfu_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bfu_pkg::D2_W-1:0]   i_value,
    output bfu_pkg::t_sqrt_rsp         o_rsp
);
    import bfu_pkg::*;

    localparam int IW = 2 * ROOT_W;
    localparam int CW = $clog2(SQRT_STEPS + 1);

    logic [IW-1:0] r_v;
    logic [IW-1:0] r_r;
    logic [IW-1:0] r_bit;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [IW-1:0] sum_rb;
    logic          ge;

    assign sum_rb = r_r + r_bit;
    assign ge     = (r_v >= sum_rb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SQRT_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= IW'(i_value);
            r_r   <= '0;
            r_bit <= IW'(1) << (IW - 2);
        end else if (r_busy) begin
            r_v   <= ge ? (r_v - sum_rb) : r_v;
            r_r   <= ge ? ((r_r >> 1) + r_bit) : (r_r >> 1);
            r_bit <= r_bit >> 2;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_r[ROOT_W-1:0];

endmodule

// ===== design/bfu_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfu_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfu_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== design/boid_flocking_update.sv =====
`timescale 1ns / 1ps
// results: write and out-of-range requests raise the result strobe straight from idle; reads pass through S_RDOUT first
// update: reads the boid, then visits every active boid in turn; one inside the separation
//   radius runs a square root then a divide, and each term with neighbors runs one more divide
// throughput: one request at a time; busy stays high until the result strobe; results never stall
// reset: configuration returns to its defaults; the boid tables are not cleared
// ----------------------------------------------------------------------------
// boid_flocking_update
// Boid table in two RAMs with a read-modify-write steering update sequencer.
// ----------------------------------------------------------------------------
module boid_flocking_update #(
    parameter int MAX_BOIDS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bfu_pkg::MODE_W-1:0]        i_mode,
    input  logic [bfu_pkg::IDX_W-1:0]         i_boid_index,
    input  bfu_pkg::t_coord                   i_pos_x_in,
    input  bfu_pkg::t_coord                   i_pos_y_in,
    input  bfu_pkg::t_coord                   i_vel_x_in,
    input  bfu_pkg::t_coord                   i_vel_y_in,
    input  logic                              i_cfg_we,
    input  logic [bfu_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [bfu_pkg::RAD_W-1:0]         i_cfg_wdata,
    output logic                              o_done,
    output bfu_pkg::t_coord                   o_pos_x_out,
    output bfu_pkg::t_coord                   o_pos_y_out,
    output bfu_pkg::t_coord                   o_vel_x_out,
    output bfu_pkg::t_coord                   o_vel_y_out,
    output logic [bfu_pkg::STAT_W-1:0]        o_status
);
    import bfu_pkg::*;

    localparam int AW = (MAX_BOIDS > 1) ? $clog2(MAX_BOIDS) : 1;
    localparam int RW = 2 * COORD_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RDOUT     = 4'd1;
    localparam logic [3:0] S_SELF      = 4'd2;
    localparam logic [3:0] S_NB_ADDR   = 4'd3;
    localparam logic [3:0] S_NB_DIFF   = 4'd4;
    localparam logic [3:0] S_NB_SQ     = 4'd5;
    localparam logic [3:0] S_NB_D2     = 4'd6;
    localparam logic [3:0] S_NB_TEST   = 4'd7;
    localparam logic [3:0] S_NB_SQRT   = 4'd8;
    localparam logic [3:0] S_NB_DIV    = 4'd9;
    localparam logic [3:0] S_FIN_MUL   = 4'd10;
    localparam logic [3:0] S_TERM_GO   = 4'd11;
    localparam logic [3:0] S_TERM_WAIT = 4'd12;
    localparam logic [3:0] S_APPLY     = 4'd13;
    localparam logic [3:0] S_POS       = 4'd14;

    localparam logic [1:0] TERM_SEP = 2'd0;
    localparam logic [1:0] TERM_ALI = 2'd1;
    localparam logic [1:0] TERM_COH = 2'd2;

    // control
    logic [3:0]        r_state;
    logic              r_done;
    logic [CNT_W-1:0]  r_active;
    logic [RAD_W-1:0]  r_sep_rad;
    logic [RAD_W-1:0]  r_ali_rad;
    logic [RAD_W-1:0]  r_coh_rad;

    // payload
    logic [SQ_W-1:0]   r_rs2, r_ra2, r_rc2;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_k, r_n;
    t_coord            r_px, r_py, r_vx, r_vy;
    t_coord            r_oth_px, r_oth_py, r_oth_vx, r_oth_vy;
    logic              r_dx_neg, r_dy_neg, r_far;
    logic [RAD_W-1:0]  r_adx, r_ady;
    logic [SQ_W-1:0]   r_sqx, r_sqy;
    logic [D2_W-1:0]   r_d2;
    logic signed [SEP_W-1:0]  r_sux, r_suy;
    logic signed [SUM_W-1:0]  r_avx, r_avy, r_cpx, r_cpy;
    logic [CNT_W-1:0]  r_ns, r_na, r_nc;
    logic signed [NUMS_W-1:0] r_prod_ax, r_prod_ay, r_prod_cx, r_prod_cy;
    logic [1:0]        r_term;
    logic              r_tneg_x, r_tneg_y;
    logic signed [T_W-1:0]    r_tx, r_ty;
    t_coord            r_nvx, r_nvy;
    logic              r_sat;
    t_coord            r_out_px, r_out_py, r_out_vx, r_out_vy;
    logic [STAT_W-1:0] r_out_st;

    logic              accept, in_range, last_k, nb_ok, sep_hit;
    logic [CNT_W-1:0]  eff_n;
    logic [AW+CNT_W-1:0] in_idx_ext, r_idx_ext, k_ext;
    logic [AW-1:0]     in_addr, idx_addr, k_addr, raddr, waddr;
    logic              ram_we;
    logic [RW-1:0]     pos_wdata, vel_wdata, pos_rdata, vel_rdata;
    t_coord            rd_px, rd_py, rd_vx, rd_vy;
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W:0]  adx, ady;

    t_sqrt_rsp         sq_rsp;
    logic              div_start, div_done_x, div_done_y;
    logic [DIV_NUM_W-1:0] div_num_x, div_num_y, div_quo_x, div_quo_y;
    logic [DIV_DEN_W-1:0] div_den;

    logic [CNT_W-1:0]  t_cnt;
    logic [TDEN_W-1:0] t_den;
    logic signed [NUMS_W-1:0] t_num_x, t_num_y;
    logic [NUMS_W-1:0] t_mag_x, t_mag_y;
    logic signed [SEP_W-1:0]  sep_qx, sep_qy;
    logic signed [T_W-1:0]    trm_qx, trm_qy;
    logic [COORD_W:0]  sat_vx, sat_vy, sat_px, sat_py;

    function automatic logic [COORD_W:0] sat_coord(input logic signed [T_W:0] v);
        logic [COORD_W:0] res;
        if ((v[T_W:COORD_W-1] == '0) || (v[T_W:COORD_W-1] == '1)) begin
            res = {1'b0, v[COORD_W-1:0]};
        end else if (v[T_W]) begin
            res = {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        if (int'(r_active) < MAX_BOIDS) begin
            eff_n = r_active;
        end else begin
            eff_n = CNT_W'(MAX_BOIDS);
        end
    end

    assign in_range = ({1'b0, i_boid_index} < eff_n);
    assign last_k   = (({1'b0, r_k} + 8'd1) >= {1'b0, r_n});

    assign in_idx_ext = {{(AW + 1){1'b0}}, i_boid_index};
    assign r_idx_ext  = {{(AW + 1){1'b0}}, r_idx};
    assign k_ext      = {{AW{1'b0}}, r_k};
    assign in_addr    = in_idx_ext[AW-1:0];
    assign idx_addr   = r_idx_ext[AW-1:0];
    assign k_addr     = k_ext[AW-1:0];

    assign raddr  = (r_state == S_IDLE) ? in_addr : k_addr;
    assign waddr  = (r_state == S_IDLE) ? in_addr : idx_addr;
    assign ram_we = (accept && in_range && (i_mode == MODE_WRITE)) || (r_state == S_POS);

    assign sat_vx = sat_coord((T_W + 1)'(r_vx) + (T_W + 1)'(r_tx));
    assign sat_vy = sat_coord((T_W + 1)'(r_vy) + (T_W + 1)'(r_ty));
    assign sat_px = sat_coord((T_W + 1)'(r_px) + (T_W + 1)'(r_nvx));
    assign sat_py = sat_coord((T_W + 1)'(r_py) + (T_W + 1)'(r_nvy));

    assign pos_wdata = (r_state == S_POS) ? {sat_px[COORD_W-1:0], sat_py[COORD_W-1:0]}
                                          : {i_pos_x_in, i_pos_y_in};
    assign vel_wdata = (r_state == S_POS) ? {r_nvx, r_nvy} : {i_vel_x_in, i_vel_y_in};

    bfu_ram #(.WIDTH(RW), .DEPTH(MAX_BOIDS)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (pos_wdata),
        .i_raddr (raddr),
        .o_rdata (pos_rdata)
    );

    bfu_ram #(.WIDTH(RW), .DEPTH(MAX_BOIDS)) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (vel_wdata),
        .i_raddr (raddr),
        .o_rdata (vel_rdata)
    );

    assign rd_px = pos_rdata[RW-1:COORD_W];
    assign rd_py = pos_rdata[COORD_W-1:0];
    assign rd_vx = vel_rdata[RW-1:COORD_W];
    assign rd_vy = vel_rdata[COORD_W-1:0];

    assign dx  = (COORD_W + 1)'(rd_px) - (COORD_W + 1)'(r_px);
    assign dy  = (COORD_W + 1)'(rd_py) - (COORD_W + 1)'(r_py);
    assign adx = dx[COORD_W] ? -dx : dx;
    assign ady = dy[COORD_W] ? -dy : dy;

    assign nb_ok   = !r_far && (r_d2 != '0);
    assign sep_hit = (r_d2 < {1'b0, r_rs2});

    bfu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_NB_TEST) && nb_ok && sep_hit),
        .i_value (r_d2),
        .o_rsp   (sq_rsp)
    );

    // term numerators and divisors
    always_comb begin
        t_cnt   = '0;
        t_den   = '0;
        t_num_x = '0;
        t_num_y = '0;
        unique case (r_term)
            TERM_SEP: begin
                t_cnt   = r_ns;
                t_den   = TDEN_W'(r_ns);
                t_num_x = NUMS_W'(r_sux);
                t_num_y = NUMS_W'(r_suy);
            end
            TERM_ALI: begin
                t_cnt   = r_na;
                t_den   = TDEN_W'(r_na) * TDEN_W'(ALIGN_DIV);
                t_num_x = NUMS_W'(r_avx) - r_prod_ax;
                t_num_y = NUMS_W'(r_avy) - r_prod_ay;
            end
            TERM_COH: begin
                t_cnt   = r_nc;
                t_den   = TDEN_W'(r_nc) * TDEN_W'(ALIGN_DIV);
                t_num_x = NUMS_W'(r_cpx) - r_prod_cx;
                t_num_y = NUMS_W'(r_cpy) - r_prod_cy;
            end
            default: begin
                t_cnt = '0;
            end
        endcase
    end

    assign t_mag_x = t_num_x[NUMS_W-1] ? NUMS_W'(-t_num_x) : NUMS_W'(t_num_x);
    assign t_mag_y = t_num_y[NUMS_W-1] ? NUMS_W'(-t_num_y) : NUMS_W'(t_num_y);

    assign div_start = ((r_state == S_NB_SQRT) && sq_rsp.done)
                    || ((r_state == S_TERM_GO) && (t_cnt != '0));
    assign div_num_x = (r_state == S_NB_SQRT) ? {r_adx, {FRAC_W{1'b0}}} : DIV_NUM_W'(t_mag_x);
    assign div_num_y = (r_state == S_NB_SQRT) ? {r_ady, {FRAC_W{1'b0}}} : DIV_NUM_W'(t_mag_y);
    assign div_den   = (r_state == S_NB_SQRT) ? sq_rsp.root : DIV_DEN_W'(t_den);

    bfu_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num_x),
        .i_den   (div_den),
        .o_done  (div_done_x),
        .o_quo   (div_quo_x)
    );

    bfu_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num_y),
        .i_den   (div_den),
        .o_done  (div_done_y),
        .o_quo   (div_quo_y)
    );

    assign sep_qx = $signed({1'b0, div_quo_x[SEP_W-2:0]});
    assign sep_qy = $signed({1'b0, div_quo_y[SEP_W-2:0]});
    assign trm_qx = $signed({1'b0, div_quo_x[T_W-2:0]});
    assign trm_qy = $signed({1'b0, div_quo_y[T_W-2:0]});

    // sequencer and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_active  <= RST_ACTIVE;
            r_sep_rad <= RST_SEP;
            r_ali_rad <= RST_ALI;
            r_coh_rad <= RST_COH;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ACTIVE: r_active  <= i_cfg_wdata[CNT_W-1:0];
                    CFG_SEP:    r_sep_rad <= i_cfg_wdata;
                    CFG_ALI:    r_ali_rad <= i_cfg_wdata;
                    CFG_COH:    r_coh_rad <= i_cfg_wdata;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!in_range || (i_mode == MODE_WRITE)) begin
                            r_done <= 1'b1;
                        end else if (i_mode == MODE_UPDATE) begin
                            r_state <= S_SELF;
                        end else begin
                            r_state <= S_RDOUT;
                        end
                    end
                end
                S_RDOUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SELF:    r_state <= S_NB_ADDR;
                S_NB_ADDR: r_state <= S_NB_DIFF;
                S_NB_DIFF: r_state <= S_NB_SQ;
                S_NB_SQ:   r_state <= S_NB_D2;
                S_NB_D2:   r_state <= S_NB_TEST;
                S_NB_TEST: begin
                    if (nb_ok && sep_hit) begin
                        r_state <= S_NB_SQRT;
                    end else begin
                        r_state <= last_k ? S_FIN_MUL : S_NB_ADDR;
                    end
                end
                S_NB_SQRT: begin
                    if (sq_rsp.done) begin
                        r_state <= S_NB_DIV;
                    end
                end
                S_NB_DIV: begin
                    if (div_done_x) begin
                        r_state <= last_k ? S_FIN_MUL : S_NB_ADDR;
                    end
                end
                S_FIN_MUL: r_state <= S_TERM_GO;
                S_TERM_GO: begin
                    if (t_cnt != '0) begin
                        r_state <= S_TERM_WAIT;
                    end else if (r_term == TERM_COH) begin
                        r_state <= S_APPLY;
                    end
                end
                S_TERM_WAIT: begin
                    if (div_done_x) begin
                        r_state <= (r_term == TERM_COH) ? S_APPLY : S_TERM_GO;
                    end
                end
                S_APPLY: r_state <= S_POS;
                S_POS: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rs2 <= SQ_W'(r_sep_rad) * SQ_W'(r_sep_rad);
        r_ra2 <= SQ_W'(r_ali_rad) * SQ_W'(r_ali_rad);
        r_rc2 <= SQ_W'(r_coh_rad) * SQ_W'(r_coh_rad);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_idx <= i_boid_index;
                    r_n   <= eff_n;
                    if (!in_range) begin
                        r_out_px <= '0;
                        r_out_py <= '0;
                        r_out_vx <= '0;
                        r_out_vy <= '0;
                        r_out_st <= ST_RANGE;
                    end else begin
                        r_out_px <= i_pos_x_in;
                        r_out_py <= i_pos_y_in;
                        r_out_vx <= i_vel_x_in;
                        r_out_vy <= i_vel_y_in;
                        r_out_st <= ST_OK;
                    end
                end
            end
            S_RDOUT: begin
                r_out_px <= rd_px;
                r_out_py <= rd_py;
                r_out_vx <= rd_vx;
                r_out_vy <= rd_vy;
                r_out_st <= ST_OK;
            end
            S_SELF: begin
                r_px  <= rd_px;
                r_py  <= rd_py;
                r_vx  <= rd_vx;
                r_vy  <= rd_vy;
                r_k   <= '0;
                r_sux <= '0;
                r_suy <= '0;
                r_avx <= '0;
                r_avy <= '0;
                r_cpx <= '0;
                r_cpy <= '0;
                r_ns  <= '0;
                r_na  <= '0;
                r_nc  <= '0;
            end
            S_NB_ADDR: begin
                r_far <= 1'b0;
            end
            S_NB_DIFF: begin
                r_oth_px <= rd_px;
                r_oth_py <= rd_py;
                r_oth_vx <= rd_vx;
                r_oth_vy <= rd_vy;
                r_dx_neg <= dx[COORD_W];
                r_dy_neg <= dy[COORD_W];
                r_adx    <= adx[RAD_W-1:0];
                r_ady    <= ady[RAD_W-1:0];
                // at least 2^31 apart on an axis lies outside every radius
                r_far    <= (adx[COORD_W:RAD_W] != '0) || (ady[COORD_W:RAD_W] != '0);
            end
            S_NB_SQ: begin
                r_sqx <= SQ_W'(r_adx) * SQ_W'(r_adx);
                r_sqy <= SQ_W'(r_ady) * SQ_W'(r_ady);
            end
            S_NB_D2: begin
                r_d2 <= D2_W'(r_sqx) + D2_W'(r_sqy);
            end
            S_NB_TEST: begin
                if (nb_ok && (r_d2 < {1'b0, r_ra2})) begin
                    r_avx <= r_avx + SUM_W'(r_oth_vx);
                    r_avy <= r_avy + SUM_W'(r_oth_vy);
                    r_na  <= r_na + 1'b1;
                end
                if (nb_ok && (r_d2 < {1'b0, r_rc2})) begin
                    r_cpx <= r_cpx + SUM_W'(r_oth_px);
                    r_cpy <= r_cpy + SUM_W'(r_oth_py);
                    r_nc  <= r_nc + 1'b1;
                end
                if (!(nb_ok && sep_hit) && !last_k) begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_NB_SQRT: begin
                r_far <= 1'b0;
            end
            S_NB_DIV: begin
                if (div_done_x) begin
                    // unit vector points away from the neighbor
                    r_sux <= r_sux + (r_dx_neg ? sep_qx : -sep_qx);
                    r_suy <= r_suy + (r_dy_neg ? sep_qy : -sep_qy);
                    r_ns  <= r_ns + 1'b1;
                    if (!last_k) begin
                        r_k <= r_k + 1'b1;
                    end
                end
            end
            S_FIN_MUL: begin
                r_prod_ax <= $signed({1'b0, r_na}) * r_vx;
                r_prod_ay <= $signed({1'b0, r_na}) * r_vy;
                r_prod_cx <= $signed({1'b0, r_nc}) * r_px;
                r_prod_cy <= $signed({1'b0, r_nc}) * r_py;
                r_term    <= TERM_SEP;
                r_tx      <= '0;
                r_ty      <= '0;
            end
            S_TERM_GO: begin
                r_tneg_x <= t_num_x[NUMS_W-1];
                r_tneg_y <= t_num_y[NUMS_W-1];
                if ((t_cnt == '0) && (r_term != TERM_COH)) begin
                    r_term <= r_term + 1'b1;
                end
            end
            S_TERM_WAIT: begin
                if (div_done_x) begin
                    r_tx <= r_tx + (r_tneg_x ? -trm_qx : trm_qx);
                    r_ty <= r_ty + (r_tneg_y ? -trm_qy : trm_qy);
                    if (r_term != TERM_COH) begin
                        r_term <= r_term + 1'b1;
                    end
                end
            end
            S_APPLY: begin
                r_nvx <= sat_vx[COORD_W-1:0];
                r_nvy <= sat_vy[COORD_W-1:0];
                r_sat <= sat_vx[COORD_W] | sat_vy[COORD_W];
            end
            S_POS: begin
                r_out_px <= sat_px[COORD_W-1:0];
                r_out_py <= sat_py[COORD_W-1:0];
                r_out_vx <= r_nvx;
                r_out_vy <= r_nvy;
                r_out_st <= (r_sat | sat_px[COORD_W] | sat_py[COORD_W]) ? ST_SAT : ST_OK;
            end
            default: begin
                r_far <= 1'b0;
            end
        endcase
    end

    assign o_done      = r_done;
    assign o_pos_x_out = r_out_px;
    assign o_pos_y_out = r_out_py;
    assign o_vel_x_out = r_out_vx;
    assign o_vel_y_out = r_out_vy;
    assign o_status    = r_out_st;

`ifndef SYNTHESIS
    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !in_range) |=> (o_done && (o_status == ST_RANGE)))
        else $error("out-of-range request did not give a range status");

    a_write_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_range && (i_mode == MODE_WRITE))
        |=> (o_done && (o_status == ST_OK) && (o_pos_x_out == $past(i_pos_x_in))))
        else $error("write request result does not echo the written entry");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result strobe while the sequencer is still working");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((r_state == S_NB_DIV) || (r_state == S_TERM_WAIT)) && div_done_x) |-> div_done_y)
        else $error("axis dividers out of step");
`endif

endmodule

// ===== sim/boid_flocking_update_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boid_flocking_update_test
// Self-checking bench for the boid table and steering update. Requests run
// in phases under changing active counts and radii; each phase first loads
// every entry in use, then mixes writes, reads, updates and out-of-range
// indexes. A predictor tracks the table and checks every result strobe.
// ----------------------------------------------------------------------------
module boid_flocking_update_test;
    import bfu_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int TABLE_SZ  = 64;
    localparam int IDLE_LIMIT = 60000;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  idx;
        t_coord            px, py, vx, vy;
    } t_boid_req;

    typedef struct {
        t_coord            px, py, vx, vy;
        logic [STAT_W-1:0] st;
    } t_boid_state;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [MODE_W-1:0] i_mode = MODE_READ;
    logic [IDX_W-1:0] i_boid_index = '0;
    t_coord i_pos_x_in = '0, i_pos_y_in = '0, i_vel_x_in = '0, i_vel_y_in = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = CFG_ACTIVE;
    logic [RAD_W-1:0] i_cfg_wdata = '0;
    logic o_done;
    t_coord o_pos_x_out, o_pos_y_out, o_vel_x_out, o_vel_y_out;
    logic [STAT_W-1:0] o_status;

    boid_flocking_update dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_coord tab_px[TABLE_SZ], tab_py[TABLE_SZ], tab_vx[TABLE_SZ], tab_vy[TABLE_SZ];
    logic [CNT_W-1:0] cfg_active = RST_ACTIVE;
    logic [RAD_W-1:0] cfg_sep = RST_SEP, cfg_ali = RST_ALI, cfg_coh = RST_COH;

    t_boid_req   pending_reqs[$];
    t_boid_state expected_boids[$];
    t_boid_req   cur_req;
    int gap_left = 0;
    int mismatches = 0, n_updates = 0, n_sat = 0, n_range = 0, n_checked = 0;
    int idle_cycles = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clip32(longint v, inout bit f);
        if (v > 64'sd2147483647) begin
            f = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            f = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void steer_boid(int me, int n, inout bit f);
        longint px, py, vx, vy, dx, dy, adx, ady, d;
        longint sux, suy, avx, avy, cpx, cpy, ns, na, nc, tx, ty, nvx, nvy;
        longint unsigned d2, rs2, ra2, rc2;
        px = tab_px[me]; py = tab_py[me]; vx = tab_vx[me]; vy = tab_vy[me];
        rs2 = longint'(cfg_sep) * longint'(cfg_sep);
        ra2 = longint'(cfg_ali) * longint'(cfg_ali);
        rc2 = longint'(cfg_coh) * longint'(cfg_coh);
        sux = 0; suy = 0; avx = 0; avy = 0; cpx = 0; cpy = 0; ns = 0; na = 0; nc = 0;
        for (int k = 0; k < n; k++) begin
            dx = longint'(tab_px[k]) - px;
            dy = longint'(tab_py[k]) - py;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            if (adx >= 64'sd2147483648 || ady >= 64'sd2147483648) continue;
            d2 = adx * adx + ady * ady;
            if (d2 == 0) continue;
            if (d2 < rs2) begin
                d = int_sqrt(d2);
                sux += (-dx * 65536) / d;
                suy += (-dy * 65536) / d;
                ns++;
            end
            if (d2 < ra2) begin
                avx += tab_vx[k];
                avy += tab_vy[k];
                na++;
            end
            if (d2 < rc2) begin
                cpx += tab_px[k];
                cpy += tab_py[k];
                nc++;
            end
        end
        tx = 0; ty = 0;
        if (ns > 0) begin
            tx += sux / ns;
            ty += suy / ns;
        end
        if (na > 0) begin
            tx += (avx - na * vx) / (20 * na);
            ty += (avy - na * vy) / (20 * na);
        end
        if (nc > 0) begin
            tx += (cpx - nc * px) / (20 * nc);
            ty += (cpy - nc * py) / (20 * nc);
        end
        nvx = clip32(vx + tx, f);
        nvy = clip32(vy + ty, f);
        tab_vx[me] = t_coord'(nvx);
        tab_vy[me] = t_coord'(nvy);
        tab_px[me] = t_coord'(clip32(px + nvx, f));
        tab_py[me] = t_coord'(clip32(py + nvy, f));
    endfunction

    function automatic t_boid_state apply_request(t_boid_req r);
        t_boid_state s;
        int n;
        bit f;
        n = (cfg_active < TABLE_SZ) ? cfg_active : TABLE_SZ;
        f = 1'b0;
        if (r.idx >= n) begin
            s = '{0, 0, 0, 0, ST_RANGE};
            return s;
        end
        if (r.mode == MODE_WRITE) begin
            tab_px[r.idx] = r.px; tab_py[r.idx] = r.py;
            tab_vx[r.idx] = r.vx; tab_vy[r.idx] = r.vy;
        end else if (r.mode == MODE_UPDATE) begin
            steer_boid(r.idx, n, f);
        end
        s = '{tab_px[r.idx], tab_py[r.idx], tab_vx[r.idx], tab_vy[r.idx],
              f ? ST_SAT : ST_OK};
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // driver: start held until accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_boids = {expected_boids, apply_request(cur_req)};
                if (cur_req.mode == MODE_UPDATE) n_updates++;
                gap_left = pick_gap();
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_mode <= cur_req.mode;
                    i_boid_index <= cur_req.idx;
                    i_pos_x_in <= cur_req.px;
                    i_pos_y_in <= cur_req.py;
                    i_vel_x_in <= cur_req.vx;
                    i_vel_y_in <= cur_req.vy;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_boid_state e;
        if (i_rst_n && o_done) begin
            if (expected_boids.size() == 0) begin
                $display("%0t: result with nothing expected: px=%h py=%h vx=%h vy=%h st=%0d",
                         $time, o_pos_x_out, o_pos_y_out, o_vel_x_out, o_vel_y_out,
                         o_status);
                mismatches++;
            end else begin
                e = expected_boids.pop_front();
                n_checked++;
                if (o_status == ST_SAT) n_sat++;
                if (o_status == ST_RANGE) n_range++;
                if (o_pos_x_out !== e.px || o_pos_y_out !== e.py || o_vel_x_out !== e.vx ||
                    o_vel_y_out !== e.vy || o_status !== e.st) begin
                    $display("%0t: expected px=%h py=%h vx=%h vy=%h st=%0d", $time,
                             e.px, e.py, e.vx, e.vy, e.st);
                    $display("%0t: actual   px=%h py=%h vx=%h vy=%h st=%0d", $time,
                             o_pos_x_out, o_pos_y_out, o_vel_x_out, o_vel_y_out, o_status);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
            default: return $signed($urandom_range(0, 32'h007fffff)) - 32'sh003fffff;
        endcase
    endfunction

    task automatic add_req(logic [MODE_W-1:0] m, int idx, t_coord px, t_coord py,
                           t_coord vx, t_coord vy);
        t_boid_req r;
        r = '{m, idx[IDX_W-1:0], px, py, vx, vy};
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || expected_boids.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_cfg(logic [CFG_IDX_W-1:0] a, logic [RAD_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        case (a)
            CFG_ACTIVE: cfg_active = v[CNT_W-1:0];
            CFG_SEP:    cfg_sep = v;
            CFG_ALI:    cfg_ali = v;
            default:    cfg_coh = v;
        endcase
    endtask

    task automatic set_phase(int act, logic [RAD_W-1:0] s, logic [RAD_W-1:0] a,
                             logic [RAD_W-1:0] c);
        drain();
        @(posedge i_clk);
        write_cfg(CFG_ACTIVE, RAD_W'(act));
        write_cfg(CFG_SEP, s);
        write_cfg(CFG_ALI, a);
        write_cfg(CFG_COH, c);
        i_cfg_we <= 1'b0;
    endtask

    // loads every entry in use, then a random mix
    task automatic random_phase(int count);
        int n, idx, r;
        logic [MODE_W-1:0] m;
        n = (cfg_active < TABLE_SZ) ? cfg_active : TABLE_SZ;
        for (int k = 0; k < n; k++)
            add_req(MODE_WRITE, k, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        for (int j = 0; j < count; j++) begin
            r = $urandom_range(0, 99);
            m = r < 50 ? MODE_UPDATE : r < 70 ? MODE_WRITE : r < 85 ? MODE_READ : MODE_SPARE;
            if (n == 0 || (n < TABLE_SZ && $urandom_range(0, 9) == 0))
                idx = $urandom_range(n, TABLE_SZ - 1);
            else
                idx = $urandom_range(0, n - 1);
            add_req(m, idx, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    function automatic logic [RAD_W-1:0] rand_radius();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return RAD_W'($urandom);
            default: return RAD_W'($urandom_range(1, 32'h00400000));
        endcase
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default configuration, one entry in use
        add_req(MODE_WRITE, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        add_req(MODE_READ, 0, '0, '0, '0, '0);
        add_req(MODE_UPDATE, 0, '0, '0, '0, '0);
        add_req(MODE_WRITE, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        add_req(MODE_UPDATE, 0, '0, '0, '0, '0);
        add_req(MODE_SPARE, 0, '0, '0, '0, '0);
        add_req(MODE_READ, 63, '1, '1, '1, '1);
        add_req(MODE_WRITE, 1, '0, '0, '0, '0);
        add_req(MODE_UPDATE, 63, '0, '0, '0, '0);

        // directed: small cluster at default radii, plus a far boid
        set_phase(4, RST_SEP, RST_ALI, RST_COH);
        add_req(MODE_WRITE, 0, 32'sh00000000, 32'sh00000000, 32'sh00010000, 32'sh00000000);
        add_req(MODE_WRITE, 1, 32'sh00030000, 32'sh00000000, 32'sh00000000, 32'sh00020000);
        add_req(MODE_WRITE, 2, 32'sh00000000, 32'shfffc0000, 32'shffff0000, 32'sh00008000);
        add_req(MODE_WRITE, 3, 32'sh7fff0000, 32'sh80000000, 32'sh00000000, 32'sh00000000);
        for (int k = 0; k < 4; k++) add_req(MODE_UPDATE, k, '0, '0, '0, '0);
        add_req(MODE_WRITE, 1, 32'sh00000000, 32'sh00000000, 32'sh00000000, 32'sh00000000);
        add_req(MODE_UPDATE, 0, '0, '0, '0, '0);
        add_req(MODE_READ, 4, '0, '0, '0, '0);

        // zero radii, zero count, overlarge count, full table with widest radii
        set_phase(6, '0, '0, '0);
        random_phase(20);
        set_phase(0, RST_SEP, RST_ALI, RST_COH);
        random_phase(10);
        set_phase(127, 32'h00100000, 32'h00200000, 32'h00300000);
        random_phase(10);
        set_phase(64, '1, '1, '1);
        random_phase(15);

        // random phases, mostly small counts
        for (int p = 0; p < 12; p++) begin
            set_phase($urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                : $urandom_range(1, 10),
                      rand_radius(), rand_radius(), rand_radius());
            random_phase(45);
        end
        drain();
        repeat (20) @(posedge i_clk);

        $display("checked %0d results: %0d updates, %0d saturated, %0d out of range",
                 n_checked, n_updates, n_sat, n_range);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
